>>> rtl/pepq_pkg.sv
package pepq_pkg;
    localparam int CAPACITY_DEF = 64;
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_POP = 2'd2;
    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_EMPTY = 3'd1;
    localparam logic [2:0] ST_UNKNOWN = 3'd2;
    localparam logic [2:0] ST_DUP = 3'd3;
    localparam logic [2:0] ST_FULL = 3'd4;
    localparam int ENTRY_W = 128;

    function automatic logic [63:0] sat_add(input logic [63:0] k, input logic [31:0] s);
        logic [64:0] sum;
        begin
            sum = {k[63], k} + {{33{s[31]}}, s};
            if (sum[64] != sum[63]) begin
                sat_add = sum[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            end else begin
                sat_add = sum[63:0];
            end
        end
    endfunction
endpackage

>>> rtl/periodic_event_priority_queue.sv
// Each transaction sweeps the store: the result is offered once the sweep has ended, and the
// next input is taken only after the result transaction, so one operation is in flight at a time.
// The memory read sets the sweep, one slot per cycle; a pop writes the advanced key back
// in the S_DONE state that follows the sweep.
// Synchronous active-low reset clears the valid bits; memory contents are left as they are
// and are used only for valid slots.
module periodic_event_priority_queue import pepq_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // operation[1:0], start_value[33:2], step[65:34], entry_id[97:66], zero fill
    input  logic [103:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // popped_key[63:0]
    output logic [63:0]   m_axis_tdata,
    // status[2:0]
    output logic [2:0]    m_axis_tuser
);
    localparam int AW = $clog2(CAPACITY);
    localparam logic [AW:0] SCAN_END = (AW+1)'(CAPACITY);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE, S_OUT} t_state;

    t_state             r_state;
    logic [CAPACITY-1:0] r_valid;
    logic [1:0]         r_op;
    logic [31:0]        r_start, r_step, r_id;
    logic [AW:0]        r_addr;
    logic [AW-1:0]      r_rd_idx;
    logic               r_rd_vld;
    logic               r_found;
    logic [AW-1:0]      r_hit;
    logic               r_best_vld;
    logic [AW-1:0]      r_best;
    logic [63:0]        r_best_key;
    logic [31:0]        r_best_step, r_best_id;
    logic               r_free_vld;
    logic [AW-1:0]      r_free;
    logic [63:0]        r_okey;
    logic [2:0]         r_ost;

    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [ENTRY_W-1:0] w_wdata, w_rdata;
    logic [63:0]        w_key;
    logic [31:0]        w_rstep, w_rid;
    logic               w_cur_vld;

    assign w_key   = w_rdata[63:0];
    assign w_rstep = w_rdata[95:64];
    assign w_rid   = w_rdata[127:96];
    assign w_cur_vld = r_rd_vld && r_valid[r_rd_idx];

    pepq_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(r_addr[AW-1:0]),
        .o_rdata(w_rdata)
    );

    always_comb begin
        w_we = 1'b0;
        w_waddr = r_best;
        w_wdata = {r_best_id, r_best_step, sat_add(r_best_key, r_best_step)};
        if (r_state == S_DONE) begin
            if (r_op == OP_POP && r_best_vld) begin
                w_we = 1'b1;
            end else if (r_op == OP_ADD && !r_found && r_free_vld) begin
                w_we = 1'b1;
                w_waddr = r_free;
                w_wdata = {r_id, r_step, {{32{r_start[31]}}, r_start}};
            end
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = r_okey;
    assign m_axis_tuser  = r_ost;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op    <= s_axis_tdata[1:0];
                        r_start <= s_axis_tdata[33:2];
                        r_step  <= s_axis_tdata[65:34];
                        r_id    <= s_axis_tdata[97:66];
                        r_addr  <= '0;
                        r_rd_vld <= 1'b0;
                        r_found <= 1'b0;
                        r_best_vld <= 1'b0;
                        r_free_vld <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_rd_idx <= r_addr[AW-1:0];
                    r_rd_vld <= (r_addr < SCAN_END);
                    if (r_addr < SCAN_END) begin
                        r_addr <= r_addr + 1'b1;
                    end
                    if (r_rd_vld) begin
                        if (!r_valid[r_rd_idx] && !r_free_vld) begin
                            r_free_vld <= 1'b1;
                            r_free <= r_rd_idx;
                        end
                        if (w_cur_vld && w_rid == r_id && !r_found) begin
                            r_found <= 1'b1;
                            r_hit <= r_rd_idx;
                        end
                        if (w_cur_vld && (!r_best_vld || $signed(w_key) < $signed(r_best_key)
                            || (w_key == r_best_key && $signed(w_rid) < $signed(r_best_id))))
                        begin
                            r_best_vld <= 1'b1;
                            r_best <= r_rd_idx;
                            r_best_key <= w_key;
                            r_best_step <= w_rstep;
                            r_best_id <= w_rid;
                        end
                    end else if (r_addr == SCAN_END) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    unique case (r_op)
                        OP_ADD: begin
                            r_okey <= '0;
                            if (r_found) begin
                                r_ost <= ST_DUP;
                            end else if (!r_free_vld) begin
                                r_ost <= ST_FULL;
                            end else begin
                                r_ost <= ST_OK;
                                r_valid[r_free] <= 1'b1;
                            end
                        end
                        OP_REMOVE: begin
                            r_okey <= '0;
                            if (!r_found) begin
                                r_ost <= ST_UNKNOWN;
                            end else begin
                                r_ost <= ST_OK;
                                r_valid[r_hit] <= 1'b0;
                            end
                        end
                        OP_POP: begin
                            if (!r_best_vld) begin
                                r_okey <= '0;
                                r_ost <= ST_EMPTY;
                            end else begin
                                r_okey <= r_best_key;
                                r_ost <= ST_OK;
                            end
                        end
                        default: begin
                            r_okey <= '0;
                            r_ost <= ST_OK;
                        end
                    endcase
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> rtl/pepq_ram.sv
module pepq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
